// ----- sv/ckvt_pkg.sv -----
// ----------------------------------------------------------------------------
// ckvt_pkg
// Types and constants shared by the compacting key/value table and its checker.
// ----------------------------------------------------------------------------
package ckvt_pkg;

  localparam int OPCODE_W = 3;
  localparam int KEY_W    = 8;
  localparam int VAL_W    = 8;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;

  localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_UPDATE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_ABOVE  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_ALL    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE      = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_W-1:0]    entry_key;
    logic [VAL_W-1:0]    entry_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    out_key;
    logic [VAL_W-1:0]    out_value;
    logic                last;
  } rsp_t;

endpackage

// ----- sv/ckvt_ram.sv -----
// ----------------------------------------------------------------------------
// ckvt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ckvt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/compacting_key_value_table.sv -----
// ----------------------------------------------------------------------------
// compacting_key_value_table
// Dense key/value table in insertion order with add, remove, update and list.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready and results leave on rsp_valid/rsp_ready.
// Entries live in one RAM with a registered read; a small sequencer walks it
// with one read per cycle, and one compare unit checks each entry as it returns.
// Update and remove scan from slot 0 at one entry per cycle until the first
// matching key; remove then moves each later entry down one slot, again one
// per cycle. A list scans every entry and gives one result per qualifying
// entry; the final result carries last, and an empty list gives one
// no-entries result.
// req_ready is low from acceptance of a valid opcode until its final result is
// in the output register; unknown opcodes are taken and dropped at once.
// A stalled receiver holds the result register; a list then pauses its scan.
// Reset empties the table and clears the output valid; stored entries are
// not cleared, since only slots below the entry count are ever read.
// ----------------------------------------------------------------------------
module compacting_key_value_table #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 8,
  parameter int VALUE_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ckvt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ckvt_pkg::rsp_t rsp
);

  import ckvt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = KEY_BITS + VALUE_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]            state;
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic                  cmp_valid;
  logic [AW-1:0]         cmp_idx;
  logic [OPCODE_W-1:0]   op;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_val;
  rsp_t                  hold;
  logic                  hold_valid;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DW-1:0]         ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DW-1:0]         ram_rdata;

  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_val;
  logic                  accept;
  logic                  out_free;
  logic                  is_list;
  logic                  hit;
  logic                  qual;
  logic                  stall;
  logic                  more;
  logic                  rsp_load;

  assign in_key    = KEY_BITS'(req.entry_key);
  assign in_val    = VALUE_BITS'(req.entry_value);
  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign rd_key    = ram_rdata[DW-1:VALUE_BITS];
  assign rd_val    = ram_rdata[VALUE_BITS-1:0];
  assign is_list   = (op == OP_ABOVE) || (op == OP_ALL);
  assign hit       = cmp_valid && !is_list && (rd_key == req_key);
  assign qual      = cmp_valid && is_list && ((op == OP_ALL) || (rd_val > req_val));
  assign stall     = qual && hold_valid && !out_free;
  assign more      = idx < count;
  assign rsp_load  = (state == S_FLUSH && out_free) ||
                     (state == S_SCAN && qual && hold_valid && out_free);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmp_idx;
    ram_wdata = ram_rdata;
    ram_raddr = idx[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept && req.opcode == OP_ADD && count < CW'(CAPACITY)) begin
          ram_we    = 1'b1;
          ram_waddr = count[AW-1:0];
          ram_wdata = {in_key, in_val};
        end
      end
      S_SCAN: begin
        if (stall) begin
          ram_raddr = cmp_idx;
        end
        if (hit && op == OP_UPDATE) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_key, req_val};
        end
      end
      S_SHIFT: begin
        if (cmp_valid) begin
          ram_we    = 1'b1;
          ram_waddr = cmp_idx - AW'(1);
        end
      end
      S_FLUSH: begin
      end
      default: begin
      end
    endcase
  end

  ckvt_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && !rsp_ready);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= req.opcode;
            req_key    <= in_key;
            req_val    <= in_val;
            idx        <= '0;
            cmp_valid  <= 1'b0;
            hold_valid <= (req.opcode == OP_ADD);
            if (req.opcode == OP_ADD) begin
              state <= S_FLUSH;
              if (count < CW'(CAPACITY)) begin
                hold  <= '{ST_OK, SLOT_W'(count), KEY_W'(in_key), VAL_W'(in_val), 1'b0};
                count <= count + CW'(1);
              end else begin
                hold <= '{ST_FULL, '0, KEY_W'(in_key), '0, 1'b0};
              end
            end else if (req.opcode == OP_REMOVE || req.opcode == OP_UPDATE ||
                         req.opcode == OP_ABOVE || req.opcode == OP_ALL) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (stall) begin
          end else if (hit) begin
            hold_valid <= 1'b1;
            if (op == OP_REMOVE) begin
              hold      <= '{ST_OK, SLOT_W'(cmp_idx), KEY_W'(req_key), VAL_W'(rd_val), 1'b0};
              idx       <= CW'(cmp_idx) + CW'(1);
              cmp_valid <= 1'b0;
              state     <= S_SHIFT;
            end else begin
              hold  <= '{ST_OK, SLOT_W'(cmp_idx), KEY_W'(req_key), VAL_W'(req_val), 1'b0};
              state <= S_FLUSH;
            end
          end else if (cmp_valid || more) begin
            if (qual) begin
              if (hold_valid) begin
                rsp <= hold;
              end
              hold       <= '{ST_OK, SLOT_W'(cmp_idx), KEY_W'(rd_key), VAL_W'(rd_val), 1'b0};
              hold_valid <= 1'b1;
            end
            cmp_valid <= more;
            cmp_idx   <= idx[AW-1:0];
            if (more) begin
              idx <= idx + CW'(1);
            end
          end else begin
            if (!is_list) begin
              hold       <= '{ST_NOT_FOUND, '0, KEY_W'(req_key), '0, 1'b0};
              hold_valid <= 1'b1;
            end
            state <= S_FLUSH;
          end
        end
        S_SHIFT: begin
          if (cmp_valid || more) begin
            cmp_valid <= more;
            cmp_idx   <= idx[AW-1:0];
            if (more) begin
              idx <= idx + CW'(1);
            end
          end else begin
            count <= count - CW'(1);
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            if (hold_valid) begin
              rsp <= '{hold.status, hold.slot, hold.out_key, hold.out_value, 1'b1};
            end else begin
              rsp <= '{ST_NONE, '0, '0, '0, 1'b1};
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/ckvt_checker.sv -----
// ----------------------------------------------------------------------------
// ckvt_checker
// Port-level checks on the compacting key/value table, bound to its top level.
// ----------------------------------------------------------------------------
module ckvt_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input ckvt_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input ckvt_pkg::rsp_t rsp
);

  import ckvt_pkg::*;

  // A request with a valid opcode makes the table busy right after it is taken.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.opcode == OP_ADD || req.opcode == OP_REMOVE ||
      req.opcode == OP_UPDATE || req.opcode == OP_ABOVE || req.opcode == OP_ALL)
    |=> !req_ready)
    else $error("table ready right after taking a request");

  // A listed entry that is not the last one belongs to a list still running.
  a_list_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> !req_ready)
    else $error("new request possible while a list is unfinished");

  // The no-entries result is always a lone, final result at slot zero.
  a_none_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_NONE |-> rsp.last && rsp.slot == '0 &&
      rsp.out_key == '0 && rsp.out_value == '0)
    else $error("malformed no-entries result");

  // A stalled result holds steady.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

endmodule

bind compacting_key_value_table ckvt_checker u_ckvt_checker (.*);
